@@ src/dhgr_pkg.sv @@
// shared types, constants and palette of the double hi-res color cell decoder
`default_nettype none
package dhgr_pkg;

   // raster geometry
   localparam int BYTES_PER_LINE  = 40;
   localparam int LINES_PER_FRAME = 192;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int COLOR_W = 32;
   localparam int POS_W   = 8;
   localparam int REQ_W   = 2 * BYTE_W;
   localparam int RSP_W   = COLOR_W + 2 * POS_W;

   // work queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // one decoded byte pair waiting to be emitted as color cells
   typedef struct packed {
      logic [15:0]      dots;      // up to four nibbles, first cell in bits 3:0
      logic [1:0]       last_idx;  // index of the final cell, 2 or 3
      logic [POS_W-1:0] cell_x;    // column of the first cell
      logic [POS_W-1:0] line;      // scanline
   } job_type;

   function automatic logic [COLOR_W-1:0] palette(input logic [3:0] nib);
      logic [COLOR_W-1:0] c;
      unique case (nib)
         4'h0: c = 32'hFF000000;
         4'h1: c = 32'hFF6622DD;
         4'h2: c = 32'hFF990000;
         4'h3: c = 32'hFF4400DD;
         4'h4: c = 32'hFF002200;
         4'h5: c = 32'hFF555555;
         4'h6: c = 32'hFFCC2200;
         4'h7: c = 32'hFFFFAA66;
         4'h8: c = 32'hFF005588;
         4'h9: c = 32'hFF0044FF;
         4'hA: c = 32'hFFAAAAAA;
         4'hB: c = 32'hFF8888FF;
         4'hC: c = 32'hFF00DD00;
         4'hD: c = 32'hFF00FFFF;
         4'hE: c = 32'hFFDDFF44;
         default: c = 32'hFFFFFFFF;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

@@ src/dhgr_front.sv @@
// front part: takes byte pairs, assembles dots into cells and tracks raster position
`default_nettype none
module dhgr_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [dhgr_pkg::BYTE_W-1:0]   aux_byte,
   input  wire logic [dhgr_pkg::BYTE_W-1:0]   main_byte,
   output dhgr_pkg::job_type                  job
);
   import dhgr_pkg::*;

   logic [2:0]       held_dots_ff,  held_dots_in;
   logic [1:0]       held_count_ff, held_count_in;
   logic [5:0]       byte_pos_ff,   byte_pos_in;
   logic [POS_W-1:0] cell_pos_ff,   cell_pos_in;
   logic [POS_W-1:0] line_pos_ff,   line_pos_in;

   logic [2:0]       held_mask;
   logic [16:0]      dots;
   logic             four_cells;
   logic [6:0]       next_byte;
   logic [POS_W:0]   next_line;

   always_comb begin
      held_mask  = 3'((4'b0001 << held_count_ff) - 4'd1);
      dots       = 17'(held_dots_ff & held_mask)
                 | (17'(aux_byte[6:0]) << held_count_ff)
                 | (17'(main_byte[6:0]) << (5'(held_count_ff) + 5'd7));
      // two or more held dots give sixteen or more, hence four cells
      four_cells = held_count_ff[1];

      job.dots     = dots[15:0];
      job.last_idx = {1'b1, four_cells};
      job.cell_x   = cell_pos_ff;
      job.line     = line_pos_ff;

      held_count_in = held_count_ff;
      held_dots_in  = held_dots_ff;
      byte_pos_in   = byte_pos_ff;
      cell_pos_in   = cell_pos_ff;
      line_pos_in   = line_pos_ff;
      next_byte     = 7'(byte_pos_ff) + 7'd1;
      next_line     = 9'(line_pos_ff) + 9'd1;

      if (accept) begin
         held_count_in = held_count_ff + 2'd2;
         held_dots_in  = four_cells ? {2'b00, dots[16]} : dots[14:12];
         cell_pos_in   = cell_pos_ff + (four_cells ? 8'd4 : 8'd3);
         byte_pos_in   = next_byte[5:0];
         // end of scanline: leftover dots are dropped
         if (next_byte >= 7'(BYTES_PER_LINE)) begin
            byte_pos_in   = '0;
            cell_pos_in   = '0;
            held_dots_in  = '0;
            held_count_in = '0;
            line_pos_in   = (next_line >= 9'(LINES_PER_FRAME)) ? '0 : next_line[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_dots_ff  <= '0;
         held_count_ff <= '0;
         byte_pos_ff   <= '0;
         cell_pos_ff   <= '0;
         line_pos_ff   <= '0;
      end else begin
         held_dots_ff  <= held_dots_in;
         held_count_ff <= held_count_in;
         byte_pos_ff   <= byte_pos_in;
         cell_pos_ff   <= cell_pos_in;
         line_pos_ff   <= line_pos_in;
      end
   end

`ifndef SYNTHESIS
   a_byte_pos_range: assert property (@(posedge clock) disable iff (reset)
      7'(byte_pos_ff) < 7'(BYTES_PER_LINE))
      else $error("byte position past end of line");
   a_line_pos_range: assert property (@(posedge clock) disable iff (reset)
      9'(line_pos_ff) < 9'(LINES_PER_FRAME))
      else $error("line position past end of frame");
   a_line_start_clean: assert property (@(posedge clock) disable iff (reset)
      (byte_pos_ff == '0) |-> (held_count_ff == '0 && cell_pos_ff == '0))
      else $error("dots or cells carried across a line start");
`endif

endmodule
`default_nettype wire

@@ src/dhgr_queue.sv @@
// short queue of decoded byte pairs between front and back
`default_nettype none
module dhgr_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire dhgr_pkg::job_type push_job,
   output logic              full,
   input  wire logic         pop,
   output logic              not_empty,
   output dhgr_pkg::job_type head_job
);
   import dhgr_pkg::*;

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff,  count_in;

   always_comb begin
      full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      not_empty = (count_ff != '0);
      head_job  = mem_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from an empty queue");
`endif

endmodule
`default_nettype wire

@@ src/dhgr_back.sv @@
// back part: emits one color cell per cycle, while the receiver is ready, into a registered output stage
`default_nettype none
module dhgr_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        job_valid,
   input  wire dhgr_pkg::job_type           job_in,
   output logic                             job_pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [dhgr_pkg::COLOR_W-1:0]     color,
   output logic [dhgr_pkg::POS_W-1:0]       cell_x,
   output logic [dhgr_pkg::POS_W-1:0]       line,
   output logic                             last
);
   import dhgr_pkg::*;

   job_type          job_ff,  job_in_r;
   logic             busy_ff, busy_in;
   logic [1:0]       k_ff,    k_in;
   logic             valid_ff, valid_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [POS_W-1:0] cell_x_ff, cell_x_in;
   logic [POS_W-1:0] line_ff,  line_in;
   logic             last_ff,  last_in;

   logic             out_load;
   logic             at_last;

   always_comb begin
      out_load = busy_ff && (!valid_ff || rsp_ready);
      at_last  = (k_ff == job_ff.last_idx);
      job_pop  = job_valid && (!busy_ff || (out_load && at_last));

      job_in_r = job_pop ? job_in : job_ff;
      busy_in  = busy_ff;
      k_in     = k_ff;
      if (job_pop) begin
         busy_in = 1'b1;
         k_in    = '0;
      end else if (out_load) begin
         busy_in = !at_last;
         k_in    = k_ff + 2'd1;
      end

      valid_in  = out_load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
      color_in  = out_load ? palette(job_ff.dots[k_ff*4 +: 4]) : color_ff;
      cell_x_in = out_load ? job_ff.cell_x + 8'(k_ff) : cell_x_ff;
      line_in   = out_load ? job_ff.line : line_ff;
      last_in   = out_load ? at_last : last_ff;

      rsp_valid = valid_ff;
      color     = color_ff;
      cell_x    = cell_x_ff;
      line      = line_ff;
      last      = last_ff;
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in_r;
      color_ff  <= color_in;
      cell_x_ff <= cell_x_in;
      line_ff   <= line_in;
      last_ff   <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         k_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
   end

`ifndef SYNTHESIS
   a_cell_index: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (k_ff <= job_ff.last_idx))
      else $error("cell index past last cell of pair");
   a_cells_per_pair: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> job_ff.last_idx[1])
      else $error("pair with fewer than three cells");
`endif

endmodule
`default_nettype wire

@@ src/double_hires_color_cell_decoder.sv @@
// top level of the double hi-res sixteen color cell decoder
//
// req channel: one item per aux/main video byte pair, in scanline order.
//   bits 0-6 of the aux byte, then bits 0-6 of the main byte, are fourteen
//   dots; bit 7 of each byte is ignored
// rsp channel: one item per four-dot color cell, carrying the rgba palette
//   word, cell column and scanline; tlast marks the final cell of a pair
// each pair gives three or four cells, leftover dots carry to the next pair
//   and are dropped at the end of a scanline
// the first cell of a pair appears once the pair has passed through the queue,
//   the job register of the back part and the output register
// throughput: one cell per cycle while the receiver is ready, so one pair
//   per three or four cells, set by the cell emitter in the back part
// the front part registers the decoded pair into a four-entry queue, so
//   pairs keep being taken while the receiver stalls until the queue fills;
//   a stalled rsp item holds steady in the output register
// reset: synchronous, clears the dot carry, raster position and queue
`default_nettype none
module double_hires_color_cell_decoder (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [dhgr_pkg::REQ_W-1:0]  req_tdata,   // aux_byte, main_byte
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [dhgr_pkg::RSP_W-1:0]       rsp_tdata,   // color, cell_x, line
   output logic                             rsp_tlast
);
   import dhgr_pkg::*;

   logic             req_accept;
   logic             queue_full;
   logic             queue_not_empty;
   logic             queue_pop;
   job_type          front_job;
   job_type          head_job;
   logic [COLOR_W-1:0] color;
   logic [POS_W-1:0] cell_x;
   logic [POS_W-1:0] line;

   // a pair is taken whenever the queue has room
   assign req_tready = !queue_full;
   assign req_accept = req_tvalid && req_tready;

   dhgr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .aux_byte  (req_tdata[BYTE_W-1:0]),
      .main_byte (req_tdata[REQ_W-1:BYTE_W]),
      .job       (front_job)
   );

   dhgr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_job  (front_job),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .head_job  (head_job)
   );

   dhgr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_not_empty),
      .job_in    (head_job),
      .job_pop   (queue_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .color     (color),
      .cell_x    (cell_x),
      .line      (line),
      .last      (rsp_tlast)
   );

   // color in the low word, then cell column, then scanline
   assign rsp_tdata = {line, cell_x, color};

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// testbench for the double hi-res color cell decoder: byte pair stream in, color cells checked
`timescale 1ns / 100ps
module tb;

   localparam int CYCLE_LIMIT     = 200_000;
   localparam int TAIL_CYCLES     = 20;

   // palette words, entry 0 in the low 32 bits
   localparam logic [511:0] RGBA_LUT = {
      32'hFFFFFFFF, 32'hFFDDFF44, 32'hFF00FFFF, 32'hFF00DD00,
      32'hFF8888FF, 32'hFFAAAAAA, 32'hFF0044FF, 32'hFF005588,
      32'hFFFFAA66, 32'hFFCC2200, 32'hFF555555, 32'hFF002200,
      32'hFF4400DD, 32'hFF990000, 32'hFF6622DD, 32'hFF000000
   };

   // one aux/main byte pair; drain makes the sender wait until all cells are back
   typedef struct {
      logic [7:0] aux;
      logic [7:0] main;
      logic       drain;
   } pair_type;

   // one expected color cell
   typedef struct {
      logic [31:0] color;
      logic [7:0]  cell_x;
      logic [7:0]  line;
      logic        last;
   } cell_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [dhgr_pkg::REQ_W-1:0]   req_tdata = '0;   // aux_byte, main_byte
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [dhgr_pkg::RSP_W-1:0]   rsp_tdata;        // color, cell_x, line
   logic                         rsp_tlast;

   // decoder state mirrored in the bench
   logic [2:0] carry_dots = '0;    // dots held for the next pair, first dot in bit 0
   logic [1:0] carry_n    = '0;    // how many held dots are valid
   logic [5:0] pair_pos   = '0;    // byte pair index within the scanline
   logic [7:0] col_pos    = '0;    // next cell column
   logic [7:0] row_pos    = '0;    // current scanline

   pair_type pending_pairs[$];
   cell_type expected_cells[$];

   int   pairs_sent     = 0;
   int   cells_seen     = 0;
   int   mismatch_count = 0;
   int   quiet_from     = 0;
   int   gap_left       = 0;
   int   stall_left     = 0;
   int   cycle_count    = 0;
   logic quiet_tail     = 1'b0;

   double_hires_color_cell_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // turn one accepted byte pair into the color cells it must produce
   task automatic decode_pair(input logic [7:0] aux, input logic [7:0] main);
      int unsigned a7, m7, held, dots, total, cells, nib, k;
      cell_type c;
      a7    = 32'(aux[6:0]);     // bit 7 is not a dot
      m7    = 32'(main[6:0]);
      held  = 32'(carry_n);
      dots  = (32'(carry_dots) & ((32'd1 << held) - 1)) | (a7 << held) | (m7 << (held + 7));
      total = held + 14;
      cells = total >> 2;
      for (k = 0; k < cells; k++) begin
         nib      = (dots >> (4 * k)) & 32'hF;
         c.color  = RGBA_LUT[nib * 32 +: 32];
         c.cell_x = col_pos;
         c.line   = row_pos;
         c.last   = (k + 1 == cells);
         expected_cells.push_back(c);
         col_pos  = col_pos + 8'd1;
      end
      carry_n    = 2'(total & 3);
      carry_dots = 3'((dots >> (4 * cells)) & 7);
      // end of scanline: leftover dots are dropped, never carried to the next line
      if (pair_pos + 1 >= dhgr_pkg::BYTES_PER_LINE) begin
         pair_pos   = '0;
         col_pos    = '0;
         carry_dots = '0;
         carry_n    = '0;
         // end of frame wraps back to scanline zero
         if (row_pos + 1 >= dhgr_pkg::LINES_PER_FRAME) begin
            row_pos = '0;
         end else begin
            row_pos = row_pos + 8'd1;
         end
      end else begin
         pair_pos = pair_pos + 6'd1;
      end
   endtask

   task automatic add_pair(input logic [7:0] aux, input logic [7:0] main, input logic drain);
      pair_type p;
      p.aux   = aux;
      p.main  = main;
      p.drain = drain;
      pending_pairs.push_back(p);
   endtask

   // byte with a bias toward all-dots-on and all-dots-off, bit 7 random
   function automatic logic [7:0] pick_byte();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         return {1'($urandom), 7'h7F};
      end else if (sel == 1) begin
         return {1'($urandom), 7'h00};
      end
      return 8'($urandom);
   endfunction

   function automatic void check_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %h actual %h", $time, what, want, got);
         mismatch_count++;
      end
   endfunction

   // sender: presents queued pairs, predicts on every accepted item, idles in bursts
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_pair(req_tdata[7:0], req_tdata[15:8]);
            pairs_sent = pairs_sent + 1;
            if (pairs_sent >= quiet_from) begin
               quiet_tail <= 1'b1;
            end else if (pairs_sent[5] && $urandom_range(0, 2) == 0) begin
               // idle stretches alternate with stretches of back-to-back items
               gap_left = $urandom_range(1, 16);
            end
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left   = gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_pairs.size() > 0 &&
                         !(pending_pairs[0].drain && expected_cells.size() > 0)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {pending_pairs[0].main, pending_pairs[0].aux};
               void'(pending_pairs.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each cell against the oldest expectation, stalls in bursts
   always @(posedge clock) begin : rsp_side
      cell_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            cells_seen = cells_seen + 1;
            if (expected_cells.size() == 0) begin
               $display("%0t unexpected cell: expected none actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               want = expected_cells.pop_front();
               check_field("color", want.color, rsp_tdata[31:0]);
               check_field("cell_x", {24'd0, want.cell_x}, {24'd0, rsp_tdata[39:32]});
               check_field("line", {24'd0, want.line}, {24'd0, rsp_tdata[47:40]});
               check_field("last", {31'd0, want.last}, {31'd0, rsp_tlast});
            end
         end
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && cells_seen[6] && $urandom_range(0, 5) == 0) begin
            // start a stall burst, this one included; stall_left holds the stalled cycles still to come
            stall_left = $urandom_range(0, 15);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL double_hires_color_cell_decoder");
         $finish;
      end
   end

   initial begin : stimulus
      int n;

      // directed: dot extremes, bit 7 set alone, alternating and split patterns
      add_pair(8'h00, 8'h00, 1'b0);
      add_pair(8'hFF, 8'hFF, 1'b0);
      add_pair(8'h7F, 8'h7F, 1'b0);
      add_pair(8'h80, 8'h80, 1'b0);
      add_pair(8'h7F, 8'h00, 1'b0);
      add_pair(8'h00, 8'h7F, 1'b0);
      add_pair(8'h55, 8'h2A, 1'b0);
      add_pair(8'h2A, 8'h55, 1'b0);
      add_pair(8'h0F, 8'h70, 1'b0);
      add_pair(8'hF0, 8'h0F, 1'b0);
      add_pair(8'h01, 8'h40, 1'b0);
      add_pair(8'hC0, 8'h81, 1'b0);

      // random pairs over several scanlines; the first waits for the directed cells to drain
      for (n = 0; n < 398; n++) begin
         add_pair(pick_byte(), pick_byte(), n == 0);
      end
      quiet_from = pending_pairs.size() - 3 * dhgr_pkg::BYTES_PER_LINE;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_pairs.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_cells.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_cells.size() == 0) begin
         $display("PASS double_hires_color_cell_decoder");
      end else begin
         $display("FAIL double_hires_color_cell_decoder");
      end
      $finish;
   end

endmodule
